>>> src/mhst_pkg.sv
// Shared constants, types and the reciprocal table of the heat source pipeline.
// No dependencies; imported by every module of the block.
package mhst_pkg;

   localparam int AXIS_NODES = 1024;
   localparam int IDX_W      = 10;
   localparam int WORD_W     = 32;
   localparam int POS_W      = IDX_W + WORD_W;          // Q24 coordinate
   localparam int XI_W       = POS_W + 1;               // signed offset from source
   localparam int MAG_W      = 31;                      // normalized magnitude
   localparam int SHIFT_W    = 4;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = 64;
   localparam int ROOT_W     = 32;
   localparam int DIST_W     = ROOT_W + POS_W - MAG_W;  // R in Q24
   localparam int W_W        = DIST_W + 1;              // R + xi, clamped
   localparam int W_HALF     = W_W / 2;
   localparam int PP_W       = WORD_W + W_HALF;
   localparam int E_W        = WORD_W + W_W;            // exponent in Q40
   localparam int E_LIM_BITS = 46;
   localparam int Y_LSB      = 15;
   localparam int Y_W        = E_LIM_BITS - Y_LSB;      // Q31 argument
   localparam int FRAC       = 31;
   localparam int TERMS      = 12;
   localparam int SQUARINGS  = 6;
   localparam int ACC_W      = WORD_W + 3;
   localparam int RCP_SHIFT  = 32;
   localparam int RCP_W      = RCP_SHIFT + 1;
   localparam int DIV_SHIFT  = 7;
   localparam int DEN_W      = DIST_W + DIV_SHIFT;
   localparam int QUO_W      = 32;
   localparam int CSR_IDX_W  = 4;

   localparam logic [WORD_W-1:0] Q31_ONE = WORD_W'(1) << FRAC;

   // floor(2^32 / k) for the Taylor term divisors k = 1 .. 12
   localparam logic [RCP_W:0] RCP_NUM = (RCP_W + 1)'(1) << RCP_SHIFT;
   localparam logic [RCP_W-1:0] RECIP [TERMS] = '{
      RCP_W'(RCP_NUM / 1),  RCP_W'(RCP_NUM / 2),  RCP_W'(RCP_NUM / 3),
      RCP_W'(RCP_NUM / 4),  RCP_W'(RCP_NUM / 5),  RCP_W'(RCP_NUM / 6),
      RCP_W'(RCP_NUM / 7),  RCP_W'(RCP_NUM / 8),  RCP_W'(RCP_NUM / 9),
      RCP_W'(RCP_NUM / 10), RCP_W'(RCP_NUM / 11), RCP_W'(RCP_NUM / 12)
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CELL_DX      = 4'd0,
      REG_CELL_DY      = 4'd1,
      REG_CELL_DZ      = 4'd2,
      REG_HALF_X       = 4'd3,
      REG_HALF_Y       = 4'd4,
      REG_AMBIENT_TEMP = 4'd5,
      REG_HEAT_GAIN    = 4'd6,
      REG_DECAY_RATE   = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] cell_dx;
      logic [WORD_W-1:0] cell_dy;
      logic [WORD_W-1:0] cell_dz;
      logic [WORD_W-1:0] half_x;
      logic [WORD_W-1:0] half_y;
      logic [WORD_W-1:0] ambient_temp;
      logic [WORD_W-1:0] heat_gain;
      logic [WORD_W-1:0] decay_rate;
   } cfg_type;

   typedef struct packed {
      logic                     valid;
      logic [SUM_W-1:0]         n;
      logic [SHIFT_W-1:0]       shift;
      logic signed [XI_W-1:0]   xi;
   } geom_type;

   typedef struct packed {
      logic                     valid;
      logic [ROOT_W-1:0]        root;
      logic [SHIFT_W-1:0]       shift;
      logic signed [XI_W-1:0]   xi;
   } root_type;

   typedef struct packed {
      logic                     valid;
      logic                     rzero;
      logic [DIST_W-1:0]        radius;
      logic [WORD_W-1:0]        v;
   } exp_type;

   typedef struct packed {
      logic                     valid;
      logic [WORD_W-1:0]        temperature;
      logic                     saturated;
   } res_type;

endpackage

>>> src/mhst_geom.sv
// Node coordinates, distance components, normalizing shift and sum of squares.
// Five register stages; depends on mhst_pkg.
module mhst_geom (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [mhst_pkg::IDX_W-1:0] x_index,
   input  logic [mhst_pkg::IDX_W-1:0] y_index,
   input  logic [mhst_pkg::IDX_W-1:0] z_index,
   input  mhst_pkg::cfg_type         cfg,
   output mhst_pkg::geom_type        out
);
   import mhst_pkg::*;

   function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] r;
      r = idx;
      if (32'(idx) >= AXIS_NODES) r = IDX_W'(AXIS_NODES - 1);
      return r;
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [POS_W-1:0] x1_ff, y1_ff, c1_ff, x1_in, y1_in, c1_in;
   logic [POS_W-1:0] a2_ff, b2_ff, c2_ff, a2_in, b2_in;
   logic signed [XI_W-1:0] xi2_ff, xi3_ff, xi4_ff, xi5_ff, xi2_in;
   logic [MAG_W-1:0] a3_ff, b3_ff, c3_ff, a3_in, b3_in, c3_in;
   logic [SHIFT_W-1:0] s3_ff, s4_ff, s5_ff, s3_in;
   logic [POS_W-1:0] m3;
   logic [SQ_W-1:0] qa4_ff, qb4_ff, qc4_ff, qa4_in, qb4_in, qc4_in;
   logic [SUM_W-1:0] n5_ff, n5_in;

   always_comb begin
      x1_in = POS_W'(clamp_idx(x_index)) * POS_W'(cfg.cell_dx);
      y1_in = POS_W'(clamp_idx(y_index)) * POS_W'(cfg.cell_dy);
      c1_in = POS_W'(clamp_idx(z_index)) * POS_W'(cfg.cell_dz);

      a2_in  = (x1_ff >= POS_W'(cfg.half_x)) ? x1_ff - POS_W'(cfg.half_x)
                                             : POS_W'(cfg.half_x) - x1_ff;
      b2_in  = (y1_ff >= POS_W'(cfg.half_y)) ? y1_ff - POS_W'(cfg.half_y)
                                             : POS_W'(cfg.half_y) - y1_ff;
      xi2_in = $signed({1'b0, x1_ff}) - $signed(XI_W'(cfg.half_x));

      // smallest shift that brings the largest magnitude below 2^31
      m3 = a2_ff;
      if (b2_ff > m3) m3 = b2_ff;
      if (c2_ff > m3) m3 = c2_ff;
      s3_in = '0;
      for (int j = 0; j < POS_W - MAG_W; j++) begin
         if (m3[MAG_W + j]) s3_in = SHIFT_W'(j + 1);
      end
      a3_in = MAG_W'(a2_ff >> s3_in);
      b3_in = MAG_W'(b2_ff >> s3_in);
      c3_in = MAG_W'(c2_ff >> s3_in);

      qa4_in = SQ_W'(a3_ff) * SQ_W'(a3_ff);
      qb4_in = SQ_W'(b3_ff) * SQ_W'(b3_ff);
      qc4_in = SQ_W'(c3_ff) * SQ_W'(c3_ff);

      n5_in = SUM_W'(qa4_ff) + SUM_W'(qb4_ff) + SUM_W'(qc4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0; v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         x1_ff <= x1_in;  y1_ff <= y1_in;  c1_ff <= c1_in;
         v2_ff <= v1_ff;
         a2_ff <= a2_in;  b2_ff <= b2_in;  c2_ff <= c1_ff;  xi2_ff <= xi2_in;
         v3_ff <= v2_ff;
         a3_ff <= a3_in;  b3_ff <= b3_in;  c3_ff <= c3_in;
         s3_ff <= s3_in;  xi3_ff <= xi2_ff;
         v4_ff <= v3_ff;
         qa4_ff <= qa4_in; qb4_ff <= qb4_in; qc4_ff <= qc4_in;
         s4_ff <= s3_ff;  xi4_ff <= xi3_ff;
         v5_ff <= v4_ff;
         n5_ff <= n5_in;  s5_ff <= s4_ff;  xi5_ff <= xi4_ff;
      end
   end

   assign out = '{valid: v5_ff, n: n5_ff, shift: s5_ff, xi: xi5_ff};

endmodule

>>> src/mhst_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on mhst_pkg.
module mhst_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  mhst_pkg::geom_type in,
   output mhst_pkg::root_type out
);
   import mhst_pkg::*;

   typedef struct packed {
      logic                   valid;
      logic [SUM_W-1:0]       rem;
      logic [ROOT_W-1:0]      root;
      logic [SHIFT_W-1:0]     shift;
      logic signed [XI_W-1:0] xi;
   } sq_stage_type;

   sq_stage_type stage_ff [ROOT_W];
   sq_stage_type src      [ROOT_W];
   sq_stage_type nxt      [ROOT_W];
   logic [SUM_W:0] trial  [ROOT_W];

   always_comb begin
      src[0] = '{valid: in.valid, rem: in.n, root: '0, shift: in.shift, xi: in.xi};
      for (int i = 1; i < ROOT_W; i++) src[i] = stage_ff[i-1];
      for (int i = 0; i < ROOT_W; i++) begin
         nxt[i] = src[i];
         // (root + 2^b)^2 - root^2
         trial[i] = ((SUM_W + 1)'(src[i].root) << (ROOT_W - i))
                  + ((SUM_W + 1)'(1) << (2 * (ROOT_W - 1 - i)));
         if ({1'b0, src[i].rem} >= trial[i]) begin
            nxt[i].rem = src[i].rem - trial[i][SUM_W-1:0];
            nxt[i].root[5'(ROOT_W - 1 - i)] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_W; i++) stage_ff[i].valid <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < ROOT_W; i++) stage_ff[i] <= nxt[i];
      end
   end

   assign out = '{valid: stage_ff[ROOT_W-1].valid, root: stage_ff[ROOT_W-1].root,
                  shift: stage_ff[ROOT_W-1].shift, xi: stage_ff[ROOT_W-1].xi};

endmodule

>>> src/mhst_exp.sv
// Exponent product and exp(-E) in Q31: Taylor series of E/64, squared six times.
// Three stages per term (multiply, reciprocal, correct); depends on mhst_pkg.
module mhst_exp (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [mhst_pkg::WORD_W-1:0] decay_rate,
   input  mhst_pkg::root_type in,
   output mhst_pkg::exp_type  out
);
   import mhst_pkg::*;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic               rzero;
      logic [DIST_W-1:0]  radius;
      logic [Y_W-1:0]     y;
      logic [WORD_W-1:0]  term;
      logic [WORD_W-1:0]  p;
      logic [WORD_W-1:0]  q0;
      logic [ACC_W-1:0]   pos;
      logic [ACC_W-1:0]   neg;
   } tay_type;

   // front stages
   logic e1_v_ff, e2_v_ff, e3_v_ff;
   logic e1_rz_ff, e2_rz_ff, e3_rz_ff, e3_zero_ff, e3_zero_in;
   logic [DIST_W-1:0] e1_dist_ff, e2_dist_ff, e3_dist_ff, e1_dist_in;
   logic [W_W-1:0] e1_w_ff, e1_w_in;
   logic signed [W_W:0] wsum;
   logic [PP_W-1:0] e2_lo_ff, e2_hi_ff, e2_lo_in, e2_hi_in;
   logic [E_W-1:0] ex;
   logic [Y_W-1:0] e3_y_ff, e3_y_in;

   tay_type ta_ff [TERMS], tb_ff [TERMS], tc_ff [TERMS];
   tay_type ta_src [TERMS], ta_in [TERMS], tb_in [TERMS], tc_in [TERMS];
   logic [2*WORD_W-1:0] pa [TERMS];
   logic [WORD_W+RCP_W-1:0] pb [TERMS];
   logic [WORD_W-1:0] rm [TERMS];

   exp_type f_ff, f_in;
   exp_type sq_ff [SQUARINGS], sq_src [SQUARINGS], sq_in [SQUARINGS];

   always_comb begin
      e1_dist_in = DIST_W'(in.root) << in.shift;
      wsum = $signed({2'b0, e1_dist_in}) + $signed({{2{in.xi[XI_W-1]}}, in.xi});
      e1_w_in = wsum[W_W] ? '0 : wsum[W_W-1:0];

      e2_lo_in = PP_W'(decay_rate) * PP_W'(e1_w_ff[W_HALF-1:0]);
      e2_hi_in = PP_W'(decay_rate) * PP_W'(e1_w_ff[W_W-1:W_HALF]);

      ex = E_W'(e2_lo_ff) + (E_W'(e2_hi_ff) << W_HALF);
      e3_zero_in = |ex[E_W-1:E_LIM_BITS];        // exponent of 64 or more
      e3_y_in = ex[E_LIM_BITS-1:Y_LSB];

      ta_src[0] = '{valid: e3_v_ff, zero: e3_zero_ff, rzero: e3_rz_ff, radius: e3_dist_ff,
                    y: e3_y_ff, term: Q31_ONE, p: '0, q0: '0,
                    pos: ACC_W'(Q31_ONE), neg: '0};
      for (int k = 1; k < TERMS; k++) ta_src[k] = tc_ff[k-1];

      for (int k = 0; k < TERMS; k++) begin
         // term * y in Q31
         ta_in[k] = ta_src[k];
         pa[k] = (2*WORD_W)'(ta_src[k].term) * (2*WORD_W)'(ta_src[k].y);
         ta_in[k].p = WORD_W'(pa[k] >> FRAC);
         // quotient estimate by reciprocal, low by at most one
         tb_in[k] = ta_ff[k];
         pb[k] = (WORD_W+RCP_W)'(ta_ff[k].p) * (WORD_W+RCP_W)'(RECIP[k]);
         tb_in[k].q0 = WORD_W'(pb[k] >> RCP_SHIFT);
         // correct and accumulate with alternating sign
         tc_in[k] = tb_ff[k];
         rm[k] = tb_ff[k].p - WORD_W'(tb_ff[k].q0 * WORD_W'(k + 1));
         tc_in[k].term = tb_ff[k].q0 + ((rm[k] >= WORD_W'(k + 1)) ? WORD_W'(1) : '0);
         if (((k + 1) % 2) == 1) tc_in[k].neg = tb_ff[k].neg + ACC_W'(tc_in[k].term);
         else                    tc_in[k].pos = tb_ff[k].pos + ACC_W'(tc_in[k].term);
      end

      f_in.valid  = tc_ff[TERMS-1].valid;
      f_in.rzero  = tc_ff[TERMS-1].rzero;
      f_in.radius = tc_ff[TERMS-1].radius;
      f_in.v      = (!tc_ff[TERMS-1].zero && tc_ff[TERMS-1].pos > tc_ff[TERMS-1].neg)
                  ? WORD_W'(tc_ff[TERMS-1].pos - tc_ff[TERMS-1].neg) : '0;

      sq_src[0] = f_ff;
      for (int k = 1; k < SQUARINGS; k++) sq_src[k] = sq_ff[k-1];
      for (int k = 0; k < SQUARINGS; k++) begin
         sq_in[k] = sq_src[k];
         sq_in[k].v = WORD_W'(((2*WORD_W)'(sq_src[k].v) * (2*WORD_W)'(sq_src[k].v)) >> FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_v_ff <= 1'b0; e2_v_ff <= 1'b0; e3_v_ff <= 1'b0;
         for (int k = 0; k < TERMS; k++) begin
            ta_ff[k].valid <= 1'b0;
            tb_ff[k].valid <= 1'b0;
            tc_ff[k].valid <= 1'b0;
         end
         f_ff.valid <= 1'b0;
         for (int k = 0; k < SQUARINGS; k++) sq_ff[k].valid <= 1'b0;
      end else if (en) begin
         e1_v_ff <= in.valid; e1_rz_ff <= (in.root == '0);
         e1_dist_ff <= e1_dist_in; e1_w_ff <= e1_w_in;
         e2_v_ff <= e1_v_ff; e2_rz_ff <= e1_rz_ff; e2_dist_ff <= e1_dist_ff;
         e2_lo_ff <= e2_lo_in; e2_hi_ff <= e2_hi_in;
         e3_v_ff <= e2_v_ff; e3_rz_ff <= e2_rz_ff; e3_dist_ff <= e2_dist_ff;
         e3_zero_ff <= e3_zero_in; e3_y_ff <= e3_y_in;
         for (int k = 0; k < TERMS; k++) begin
            ta_ff[k] <= ta_in[k];
            tb_ff[k] <= tb_in[k];
            tc_ff[k] <= tc_in[k];
         end
         f_ff <= f_in;
         for (int k = 0; k < SQUARINGS; k++) sq_ff[k] <= sq_in[k];
      end
   end

   assign out = sq_ff[SQUARINGS-1];

endmodule

>>> src/mhst_div.sv
// Rise = gain*v / (R*128) by restoring division, then ambient add and saturation.
// One quotient bit per stage; depends on mhst_pkg.
module mhst_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [mhst_pkg::WORD_W-1:0] heat_gain,
   input  logic [mhst_pkg::WORD_W-1:0] ambient_temp,
   input  mhst_pkg::exp_type  in,
   output mhst_pkg::res_type  out
);
   import mhst_pkg::*;

   typedef struct packed {
      logic               valid;
      logic               rzero;
      logic               ovf;
      logic [DEN_W-1:0]   den;
      logic [SUM_W-1:0]   rem;
      logic [QUO_W-1:0]   quo;
   } dv_type;

   dv_type d1_ff, d1_in, d2_ff, d2_in;
   dv_type st_ff [QUO_W], st_src [QUO_W], st_in [QUO_W];
   logic [WORD_W:0] total;
   logic sat;
   res_type out_ff, out_in;

   always_comb begin
      d1_in = '{valid: in.valid, rzero: in.rzero, ovf: 1'b0,
                den: DEN_W'(in.radius) << DIV_SHIFT,
                rem: SUM_W'(heat_gain) * SUM_W'(in.v), quo: '0};

      // quotient of 2^32 or more overflows the sum anyway
      d2_in = d1_ff;
      d2_in.ovf = DEN_W'(d1_ff.rem[SUM_W-1:WORD_W]) >= d1_ff.den;

      st_src[0] = d2_ff;
      for (int i = 1; i < QUO_W; i++) st_src[i] = st_ff[i-1];
      for (int i = 0; i < QUO_W; i++) begin
         st_in[i] = st_src[i];
         if ((st_src[i].rem >> (QUO_W - 1 - i)) >= SUM_W'(st_src[i].den)) begin
            st_in[i].rem = st_src[i].rem - (SUM_W'(st_src[i].den) << (QUO_W - 1 - i));
            st_in[i].quo[5'(QUO_W - 1 - i)] = 1'b1;
         end
      end

      total = (WORD_W + 1)'(ambient_temp) + (WORD_W + 1)'(st_ff[QUO_W-1].quo);
      sat = st_ff[QUO_W-1].rzero | st_ff[QUO_W-1].ovf | total[WORD_W];
      out_in = '{valid: st_ff[QUO_W-1].valid,
                 temperature: sat ? '1 : total[WORD_W-1:0], saturated: sat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff.valid <= 1'b0;
         d2_ff.valid <= 1'b0;
         for (int i = 0; i < QUO_W; i++) st_ff[i].valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         for (int i = 0; i < QUO_W; i++) st_ff[i] <= st_in[i];
         out_ff <= out_in;
      end
   end

   assign out = out_ff;

endmodule

>>> src/moving_heat_source_temperature_unit.sv
// Top level of the moving point heat source temperature pipeline.
// Holds the CSRs and stall control; instantiates mhst_geom, mhst_sqrt, mhst_exp, mhst_div.

// Steady-state temperature of one grid node under a moving point heat source
// (Rosenthal thick-plate solution): T = ambient + gain/R * exp(-rate*(R + xi)),
// with coordinates in Q8.24 meters and temperatures in Q16.16 kelvin. One node
// beat is taken every clock while req_ready is high and passes 118 register
// stages: 5 stages of coordinates and squares, 32 stages of square root (one
// root bit each), 46 stages of exponential (exponent product, three per Taylor
// term, six squarings) and 35 stages of division (one quotient bit each) with
// the final ambient add. A result refused by the receiver moves into a one-beat
// output register; the whole pipeline holds while that register is full, so
// req_ready drops in the cycle after the first refused result and comes back
// the cycle after it is taken. R = 0 or a sum above 0xFFFFFFFF returns
// 0xFFFFFFFF with rsp_saturated set. CSRs reset to zero and are always ready;
// the user must write them only while no node is in flight, which the block
// itself does not enforce. Unknown indexes are ignored. No clearing pass is
// needed after reset.
module moving_heat_source_temperature_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mhst_pkg::IDX_W-1:0]    req_x_index,
   input  logic [mhst_pkg::IDX_W-1:0]    req_y_index,
   input  logic [mhst_pkg::IDX_W-1:0]    req_z_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mhst_pkg::WORD_W-1:0]   rsp_temperature,
   output logic                          rsp_saturated,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mhst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mhst_pkg::WORD_W-1:0]   csr_data
);
   import mhst_pkg::*;

   cfg_type  cfg_ff;
   geom_type geom;
   root_type root;
   exp_type  expo;
   res_type  res;
   logic     en;
   logic     skid_valid_ff;
   logic [WORD_W-1:0] skid_temp_ff;
   logic     skid_sat_ff;

   // advance everything unless a refused beat sits in the output register
   assign en        = !skid_valid_ff;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CELL_DX:      cfg_ff.cell_dx      <= csr_data;
            REG_CELL_DY:      cfg_ff.cell_dy      <= csr_data;
            REG_CELL_DZ:      cfg_ff.cell_dz      <= csr_data;
            REG_HALF_X:       cfg_ff.half_x       <= csr_data;
            REG_HALF_Y:       cfg_ff.half_y       <= csr_data;
            REG_AMBIENT_TEMP: cfg_ff.ambient_temp <= csr_data;
            REG_HEAT_GAIN:    cfg_ff.heat_gain    <= csr_data;
            REG_DECAY_RATE:   cfg_ff.decay_rate   <= csr_data;
            default: ;
         endcase
      end
   end

   // output register: catches the tail beat when the receiver refuses it
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) skid_valid_ff <= 1'b0;
      end else if (res.valid && !rsp_ready) begin
         skid_valid_ff <= 1'b1;
         skid_temp_ff  <= res.temperature;
         skid_sat_ff   <= res.saturated;
      end
   end

   mhst_geom u_geom (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid && req_ready),
      .x_index  (req_x_index),
      .y_index  (req_y_index),
      .z_index  (req_z_index),
      .cfg      (cfg_ff),
      .out      (geom)
   );

   mhst_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (geom),
      .out   (root)
   );

   mhst_exp u_exp (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .decay_rate (cfg_ff.decay_rate),
      .in         (root),
      .out        (expo)
   );

   mhst_div u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .heat_gain    (cfg_ff.heat_gain),
      .ambient_temp (cfg_ff.ambient_temp),
      .in           (expo),
      .out          (res)
   );

   assign rsp_valid       = skid_valid_ff || res.valid;
   assign rsp_temperature = skid_valid_ff ? skid_temp_ff : res.temperature;
   assign rsp_saturated   = skid_valid_ff ? skid_sat_ff  : res.saturated;

`ifndef NO_ASSERTIONS
   // a full output register blocks new nodes
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !req_ready)
      else $error("node accepted while output register full");

   // a refused result is offered again unchanged
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature)
                                  && $stable(rsp_saturated))
      else $error("refused result changed");

   // saturation always reports full scale
   a_sat_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_temperature == '1)
      else $error("saturated result not at full scale");

   // rise is never negative
   a_not_below_ambient: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_saturated |-> rsp_temperature >= cfg_ff.ambient_temp)
      else $error("temperature below ambient");
`endif

endmodule

>>> tb/tb_moving_heat_source_temperature_unit.sv
// Testbench of moving_heat_source_temperature_unit: a directed node table at reset CSRs,
// expected saturated, then random nodes under several CSR settings and idle patterns,
// checked by a local temperature model. Depends on mhst_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_moving_heat_source_temperature_unit;
   import mhst_pkg::*;

   localparam int CLK_HALF   = 10;
   localparam int DRAIN_WAIT = 130;     // extra wait after the expectation queues are empty
   localparam int STALL_MAX  = 20000;   // cycles without any beat before giving up
   localparam int HOLD_LEN   = 400;     // long receiver hold-off, fills the pipeline
   localparam int PHASES     = 8;
   localparam int PHASE_NODES = 190;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 4'd8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 4'd15;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam longint unsigned EXP_LIMIT = (64'd1 << E_LIM_BITS) - 64'd1;

   typedef struct {
      logic [IDX_W-1:0] ix, iy, iz;
   } node_row;

   typedef struct {
      logic [WORD_W-1:0] temperature;
      logic              saturated;
   } temp_result;

   typedef struct {
      bit         typed;      // expectation given directly, not from the model
      temp_result res;
   } pending_node;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [IDX_W-1:0] req_x_index = '0, req_y_index = '0, req_z_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [WORD_W-1:0] rsp_temperature;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0] csr_data = '0;

   cfg_type     csr_shadow;
   temp_result  temp_expect_q[$];
   pending_node node_info_q[$];
   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_start = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   moving_heat_source_temperature_unit u_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_x_index, .req_y_index, .req_z_index,
      .rsp_valid, .rsp_ready, .rsp_temperature, .rsp_saturated,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #(CLK_HALF) clock = ~clock;

   // Floor square root, one result bit per pass.
   function automatic longint unsigned isqrt64(input longint unsigned n);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= r + bitv) begin
            n = n - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // exp(-e) with e in Q40, result Q31: Taylor series on e/64, then six squarings.
   function automatic longint unsigned decay_q31(input longint unsigned e40);
      longint unsigned arg, pos, neg, term, v;
      arg = e40 >> Y_LSB;
      pos = 64'd1 << FRAC;
      neg = 0;
      term = 64'd1 << FRAC;
      for (int k = 1; k <= TERMS; k++) begin
         term = ((term * arg) >> FRAC) / k;
         if (k % 2 == 1) neg = neg + term;
         else pos = pos + term;
      end
      v = (pos > neg) ? pos - neg : 0;
      for (int k = 0; k < SQUARINGS; k++) v = (v * v) >> FRAC;
      return v;
   endfunction

   function automatic temp_result node_temperature(input cfg_type c, input logic [IDX_W-1:0] ix,
                                                   input logic [IDX_W-1:0] iy,
                                                   input logic [IDX_W-1:0] iz);
      longint unsigned px, py, pz, ax, ay, mx, rdist, v, rise, total;
      longint signed   xi, w;
      int              sh;
      temp_result      res;
      px = 64'(ix) * 64'(c.cell_dx);
      py = 64'(iy) * 64'(c.cell_dy);
      pz = 64'(iz) * 64'(c.cell_dz);
      xi = longint'(px) - longint'(64'(c.half_x));
      ax = (px >= 64'(c.half_x)) ? px - 64'(c.half_x) : 64'(c.half_x) - px;
      ay = (py >= 64'(c.half_y)) ? py - 64'(c.half_y) : 64'(c.half_y) - py;
      mx = ax;
      if (ay > mx) mx = ay;
      if (pz > mx) mx = pz;
      sh = 0;
      while ((mx >> sh) >= (64'd1 << FRAC)) sh++;
      rdist = isqrt64((ax >> sh) * (ax >> sh) + (ay >> sh) * (ay >> sh)
                      + (pz >> sh) * (pz >> sh)) << sh;
      if (rdist == 0) begin
         res.temperature = ALL_ONES;
         res.saturated = 1'b1;
         return res;
      end
      w = longint'(rdist) + xi;
      if (w < 0) w = 0;
      if (c.decay_rate == 0) v = decay_q31(0);
      else if (longint'(w) > EXP_LIMIT / 64'(c.decay_rate)) v = 0;
      else v = decay_q31(64'(c.decay_rate) * 64'(w));
      rise = ((64'(c.heat_gain) * v) / rdist) >> DIV_SHIFT;
      total = 64'(c.ambient_temp) + rise;
      if (total > 64'(ALL_ONES)) begin
         res.temperature = ALL_ONES;
         res.saturated = 1'b1;
      end else begin
         res.temperature = total[31:0];
         res.saturated = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR t=%0t %s: got %h, want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Beat monitor: predictions on node acceptance, checks on result acceptance.
   always @(posedge clock) begin
      pending_node pn;
      temp_result  want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pn = node_info_q.pop_front();
            if (pn.typed) temp_expect_q.push_back(pn.res);
            else temp_expect_q.push_back(node_temperature(csr_shadow, req_x_index,
                                                          req_y_index, req_z_index));
         end
         if (rsp_valid && rsp_ready) begin
            if (temp_expect_q.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_temperature, 32'h0);
            end else begin
               want = temp_expect_q.pop_front();
               if (rsp_temperature !== want.temperature)
                  report_mismatch("temperature", rsp_temperature, want.temperature);
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", 32'(rsp_saturated), 32'(want.saturated));
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_start) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_LEN;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles without any beat.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("moving_heat_source_temperature_unit: mismatch");
         $finish;
      end
   end

   // One CSR beat; valid stays up for back-to-back writes, the caller drops it.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_CELL_DX:      csr_shadow.cell_dx = data;
         REG_CELL_DY:      csr_shadow.cell_dy = data;
         REG_CELL_DZ:      csr_shadow.cell_dz = data;
         REG_HALF_X:       csr_shadow.half_x = data;
         REG_HALF_Y:       csr_shadow.half_y = data;
         REG_AMBIENT_TEMP: csr_shadow.ambient_temp = data;
         REG_HEAT_GAIN:    csr_shadow.heat_gain = data;
         REG_DECAY_RATE:   csr_shadow.decay_rate = data;
         default: ;        // unknown index, block ignores it
      endcase
   endtask

   // One node beat; returns at the edge where it was taken.
   task automatic send_node(input logic [IDX_W-1:0] ix, input logic [IDX_W-1:0] iy,
                            input logic [IDX_W-1:0] iz, input bit typed, input temp_result res);
      pending_node pn;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pn.typed = typed;
      pn.res = res;
      node_info_q.push_back(pn);
      req_valid <= 1'b1;
      req_x_index <= ix;
      req_y_index <= iy;
      req_z_index <= iz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (temp_expect_q.size() != 0 || node_info_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [IDX_W-1:0] near_index(input logic [31:0] pos, input logic [31:0] step);
      longint signed k;
      k = (step == 0) ? longint'($urandom_range(1023, 0)) : longint'(pos / step);
      k = k + longint'($urandom_range(2, 0)) - 1;
      if (k < 0) k = 0;
      if (k > AXIS_NODES - 1) k = AXIS_NODES - 1;
      return IDX_W'(k);
   endfunction

   node_row dir_rows[] = '{
      '{10'd0, 10'd0, 10'd0},       '{10'd1023, 10'd1023, 10'd1023},
      '{10'd1023, 10'd0, 10'd0},    '{10'd0, 10'd1023, 10'd0},
      '{10'd0, 10'd0, 10'd1023},    '{10'd512, 10'd512, 10'd0},
      '{10'd512, 10'd512, 10'd1},   '{10'd511, 10'd512, 10'd0},
      '{10'd513, 10'd512, 10'd0},   '{10'd512, 10'd0, 10'd0},
      '{10'd0, 10'd512, 10'd0},     '{10'd1, 10'd1, 10'd1},
      '{10'd341, 10'd682, 10'd5},   '{10'd682, 10'd341, 10'd1023},
      '{10'd1023, 10'd512, 10'd512}
   };

   initial begin
      cfg_type    next_cfg;
      temp_result at_source;
      logic [31:0] step;
      csr_shadow = '0;
      at_source.temperature = ALL_ONES;
      at_source.saturated = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset CSRs are all zero, so every node sits on the source.
      foreach (dir_rows[i])
         send_node(dir_rows[i].ix, dir_rows[i].iy, dir_rows[i].iz, 1'b1, at_source);
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         step = 32'h0004_0000;                      // 1/64 m
         case (ph)
            0, 4: next_cfg = '{step, step, step, 32'd512 * step, 32'd512 * step,
                               32'd300 << 16, 32'd50 << 16, 32'd4 << 16};
            1: next_cfg = '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                            ALL_ONES, ALL_ONES, ALL_ONES};
            2: next_cfg = '{32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, ALL_ONES, 32'd0};
            default: begin
               step = $urandom_range(32'h0100_0000, 1);
               next_cfg = '{step, $urandom_range(32'h0100_0000, 1), $urandom(),
                            step * $urandom_range(1023, 0), $urandom(),
                            $urandom(), $urandom(), $urandom_range(32'h0100_0000, 0)};
            end
         endcase
         csr_write(REG_CELL_DX, next_cfg.cell_dx);
         csr_write(REG_CELL_DY, next_cfg.cell_dy);
         csr_write(REG_CELL_DZ, next_cfg.cell_dz);
         csr_write(REG_HALF_X, next_cfg.half_x);
         csr_write(REG_HALF_Y, next_cfg.half_y);
         csr_write(REG_AMBIENT_TEMP, next_cfg.ambient_temp);
         csr_write(REG_HEAT_GAIN, next_cfg.heat_gain);
         csr_write(REG_DECAY_RATE, next_cfg.decay_rate);
         csr_write(CSR_IDX_W'($urandom_range(CSR_UNUSED_HI, CSR_UNUSED_LO)), $urandom());
         csr_valid <= 1'b0;
         @(posedge clock);

         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase

         if (ph == 0) begin
            foreach (dir_rows[i])
               send_node(dir_rows[i].ix, dir_rows[i].iy, dir_rows[i].iz, 1'b0, at_source);
         end

         // Long receiver hold-off while nodes keep coming.
         if (ph == 4) begin
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end

         for (int n = 0; n < PHASE_NODES; n++) begin
            // Sender pause until every result is back.
            if (ph == 5 && n == PHASE_NODES / 2) begin
               req_valid <= 1'b0;
               while (temp_expect_q.size() != 0 || node_info_q.size() != 0)
                  @(posedge clock);
            end
            if ($urandom_range(99, 0) < 15)
               send_node(near_index(csr_shadow.half_x, csr_shadow.cell_dx),
                         near_index(csr_shadow.half_y, csr_shadow.cell_dy),
                         IDX_W'($urandom_range(1, 0)), 1'b0, at_source);
            else
               send_node(IDX_W'($urandom()), IDX_W'($urandom()), IDX_W'($urandom()),
                         1'b0, at_source);
         end
         wait_drained();
      end

      if (error_count == 0)
         $display("moving_heat_source_temperature_unit: match");
      else
         $display("moving_heat_source_temperature_unit: mismatch");
      $finish;
   end

endmodule

>>> sim.f
src/mhst_pkg.sv
src/mhst_geom.sv
src/mhst_sqrt.sv
src/mhst_exp.sv
src/mhst_div.sv
src/moving_heat_source_temperature_unit.sv
tb/tb_moving_heat_source_temperature_unit.sv
